@@ rtl/core/srds_pkg.sv @@
// ----------------------------------------------------------------------------
// srds_pkg
// shared types, codes and defaults for the swap-remove dense set
// ----------------------------------------------------------------------------
package srds_pkg;

	// default sizes
	localparam int DEF_CAPACITY = 256;
	localparam int DEF_ID_SPACE = 256;

	// fixed field widths
	localparam int ID_W        = 8;
	localparam int SLOT_OUT_W  = 8;
	localparam int COUNT_OUT_W = 9;
	localparam int STATUS_W    = 2;

	// operation codes
	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FATAL   = 2'd3;

	// per-port memory strobes
	typedef struct packed {
		logic rd;
		logic wr;
	} mem_ctl_t;

endpackage

@@ rtl/core/srds_slot_mem.sv @@
// ----------------------------------------------------------------------------
// srds_slot_mem
// per-identifier slot record (valid bit + slot), cleared by a sweep after reset
// ----------------------------------------------------------------------------
module srds_slot_mem import srds_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int ID_SPACE = DEF_ID_SPACE
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mem_ctl_t                     ctl,
	input  logic [$clog2(ID_SPACE)-1:0]  raddr,
	input  logic [$clog2(ID_SPACE)-1:0]  waddr,
	input  logic                         wvalid,
	input  logic [$clog2(CAPACITY)-1:0]  wslot,
	output logic                         rvalid,
	output logic [$clog2(CAPACITY)-1:0]  rslot,
	output logic                         busy
);

	localparam int IDW = $clog2(ID_SPACE);
	localparam int SW  = $clog2(CAPACITY);

	logic [SW:0]      mem [ID_SPACE];
	logic [SW:0]      rd_q;
	logic [IDW-1:0]   clr_q;
	logic             busy_q;

	logic             we;
	logic [IDW-1:0]   wa;
	logic [SW:0]      wd;

	// clear sweep has the port while busy
	always_comb begin
		if (busy_q) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else begin
			we = ctl.wr;
			wa = waddr;
			wd = {wvalid, wslot};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (ctl.rd) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + IDW'(1);
			if (clr_q == IDW'(ID_SPACE - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign rvalid = rd_q[SW];
	assign rslot  = rd_q[SW-1:0];
	assign busy   = busy_q;

endmodule

@@ rtl/core/srds_list_mem.sv @@
// ----------------------------------------------------------------------------
// srds_list_mem
// packed list of identifiers in slot order
// ----------------------------------------------------------------------------
module srds_list_mem import srds_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                         clk,
	input  mem_ctl_t                     ctl,
	input  logic [$clog2(CAPACITY)-1:0]  raddr,
	input  logic [$clog2(CAPACITY)-1:0]  waddr,
	input  logic [ID_W-1:0]              wdata,
	output logic [ID_W-1:0]              rdata
);

	logic [ID_W-1:0] mem [CAPACITY];
	logic [ID_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

@@ rtl/core/srds_ctrl.sv @@
// ----------------------------------------------------------------------------
// srds_ctrl
// operation sequencer: lookup, read-modify-write, swap fix-up, result register
// ----------------------------------------------------------------------------
module srds_ctrl import srds_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int ID_SPACE = DEF_ID_SPACE
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input beat
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_op,
	input  logic [ID_W-1:0]              in_id,
	// result beat
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [STATUS_W-1:0]          out_status,
	output logic [SLOT_OUT_W-1:0]        out_slot,
	output logic [COUNT_OUT_W-1:0]       out_count,
	input  logic                         fatal,
	input  logic                         clr_busy,
	// slot record memory
	output mem_ctl_t                     slot_ctl,
	output logic [$clog2(ID_SPACE)-1:0]  slot_raddr,
	output logic [$clog2(ID_SPACE)-1:0]  slot_waddr,
	output logic                         slot_wvalid,
	output logic [$clog2(CAPACITY)-1:0]  slot_wslot,
	input  logic                         slot_rvalid,
	input  logic [$clog2(CAPACITY)-1:0]  slot_rslot,
	// packed list memory
	output mem_ctl_t                     list_ctl,
	output logic [$clog2(CAPACITY)-1:0]  list_raddr,
	output logic [$clog2(CAPACITY)-1:0]  list_waddr,
	output logic [ID_W-1:0]              list_wdata,
	input  logic [ID_W-1:0]              list_rdata
);

	localparam int IDW = $clog2(ID_SPACE);
	localparam int SW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_MOVE
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic                    op_q;
	logic [ID_W-1:0]         id_q;
	logic [SW-1:0]           ref_q;
	logic [ID_W-1:0]         moved_q;
	logic                    out_valid_q;
	logic [STATUS_W-1:0]     out_status_q;
	logic [SLOT_OUT_W-1:0]   out_slot_q;
	logic [COUNT_OUT_W-1:0]  out_count_q;

	logic                    acc;
	logic                    out_free;
	logic                    in_range;
	logic                    full;
	logic [CW-1:0]           last;
	logic                    finish;
	logic                    do_add;
	logic                    do_rem;
	logic                    do_move;
	logic [STATUS_W-1:0]     res_status;
	logic [SW-1:0]           res_slot;
	logic [CW-1:0]           res_count;

	assign in_ready = (state_q == S_IDLE) && !clr_busy;
	assign acc      = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign in_range = 32'(id_q) < 32'(ID_SPACE);
	assign full     = count_q == CW'(CAPACITY);
	assign last     = count_q - CW'(1);
	assign finish   = (state_q == S_LOOK) && out_free;

	// decision on the looked-up record
	always_comb begin
		do_add     = 1'b0;
		do_rem     = 1'b0;
		do_move    = 1'b0;
		res_status = ST_OK;
		res_slot   = '0;
		res_count  = count_q;
		if (fatal) begin
			res_status = ST_FATAL;
		end else if (op_q == OP_ADD) begin
			if (!in_range) begin
				res_status = ST_FULL;
			end else if (slot_rvalid) begin
				res_status = ST_PRESENT;
			end else if (full) begin
				res_status = ST_FULL;
			end else begin
				do_add    = 1'b1;
				res_slot  = SW'(count_q);
				res_count = count_q + CW'(1);
			end
		end else begin
			if (in_range && slot_rvalid && (count_q != '0)) begin
				do_rem    = 1'b1;
				res_slot  = slot_rslot;
				res_count = last;
				do_move   = CW'(slot_rslot) < (last - CW'(1)) + CW'(1)
					&& CW'(slot_rslot) != last;
			end
		end
	end

	// memory requests
	always_comb begin
		slot_ctl.rd = acc;
		slot_raddr  = IDW'(in_id);
		list_ctl.rd = acc;
		list_raddr  = SW'(count_q - CW'(1));
		slot_ctl.wr = 1'b0;
		slot_waddr  = IDW'(id_q);
		slot_wvalid = 1'b0;
		slot_wslot  = slot_rslot;
		list_ctl.wr = 1'b0;
		list_waddr  = SW'(count_q);
		list_wdata  = id_q;
		if (finish && do_add) begin
			slot_ctl.wr = 1'b1;
			slot_wvalid = 1'b1;
			slot_wslot  = SW'(count_q);
			list_ctl.wr = 1'b1;
		end else if (finish && do_rem) begin
			slot_ctl.wr = 1'b1;
			if (do_move) begin
				list_ctl.wr = 1'b1;
				list_waddr  = slot_rslot;
				list_wdata  = list_rdata;
			end
		end else if (state_q == S_MOVE) begin
			slot_ctl.wr = 1'b1;
			slot_waddr  = IDW'(moved_q);
			slot_wvalid = 1'b1;
			slot_wslot  = ref_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			op_q         <= OP_ADD;
			id_q         <= '0;
			ref_q        <= '0;
			moved_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_slot_q   <= '0;
			out_count_q  <= '0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						op_q    <= in_op;
						id_q    <= in_id;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (out_free) begin
						count_q      <= res_count;
						ref_q        <= slot_rslot;
						moved_q      <= list_rdata;
						out_status_q <= res_status;
						out_slot_q   <= SLOT_OUT_W'(res_slot);
						out_count_q  <= COUNT_OUT_W'(res_count);
						state_q      <= (do_rem && do_move) ? S_MOVE : S_IDLE;
					end
				end
				S_MOVE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot   = out_slot_q;
	assign out_count  = out_count_q;

endmodule

@@ rtl/core/swap_remove_dense_set.sv @@
// ----------------------------------------------------------------------------
// swap_remove_dense_set
// set of item identifiers kept as a packed list with a per-identifier slot
// record; add appends, remove swaps the last entry into the freed slot
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    tuser: operation, tdata: item_id
//  m_*       out  m_tvalid / m_tready    tuser: status, tdata: slot, count
//  cfg_*     in   cfg_valid / cfg_ready  cfg_data: fatal_halt
//
//  add, remove of an absent item, rejected or fatal operation: the slot record
//  is read, then written back where the set changes as the result register is
//  loaded; no new beat is taken until the operation is done. a remove that
//  moves the last entry passes through an extra state, S_MOVE, for the second
//  write to the single write port of the slot record memory.
//  after reset the slot record memory is swept clear, every identifier in turn,
//  with s_tready low; config writes are taken during the sweep.
//  a waiting result does not block the next input beat; only the step that
//  loads the result register stalls until it is free.
//
module swap_remove_dense_set import srds_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int ID_SPACE = DEF_ID_SPACE
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] item_id
	input  logic [0:0]  s_tuser,   // [0] operation
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] slot, [16:8] count, [23:17] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // fatal_halt
);

	localparam int IDW = $clog2(ID_SPACE);
	localparam int SW  = $clog2(CAPACITY);

	logic                    fatal_q;
	logic                    clr_busy;

	mem_ctl_t                slot_ctl;
	logic [IDW-1:0]          slot_raddr;
	logic [IDW-1:0]          slot_waddr;
	logic                    slot_wvalid;
	logic [SW-1:0]           slot_wslot;
	logic                    slot_rvalid;
	logic [SW-1:0]           slot_rslot;

	mem_ctl_t                list_ctl;
	logic [SW-1:0]           list_raddr;
	logic [SW-1:0]           list_waddr;
	logic [ID_W-1:0]         list_wdata;
	logic [ID_W-1:0]         list_rdata;

	logic [STATUS_W-1:0]     res_status;
	logic [SLOT_OUT_W-1:0]   res_slot;
	logic [COUNT_OUT_W-1:0]  res_count;

	// fatal halt register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fatal_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			fatal_q <= cfg_data;
		end
	end

	// sequencer
	srds_ctrl #(
		.CAPACITY (CAPACITY),
		.ID_SPACE (ID_SPACE)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_op       (s_tuser[0]),
		.in_id       (s_tdata),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (res_status),
		.out_slot    (res_slot),
		.out_count   (res_count),
		.fatal       (fatal_q),
		.clr_busy    (clr_busy),
		.slot_ctl    (slot_ctl),
		.slot_raddr  (slot_raddr),
		.slot_waddr  (slot_waddr),
		.slot_wvalid (slot_wvalid),
		.slot_wslot  (slot_wslot),
		.slot_rvalid (slot_rvalid),
		.slot_rslot  (slot_rslot),
		.list_ctl    (list_ctl),
		.list_raddr  (list_raddr),
		.list_waddr  (list_waddr),
		.list_wdata  (list_wdata),
		.list_rdata  (list_rdata)
	);

	// slot record per identifier
	srds_slot_mem #(
		.CAPACITY (CAPACITY),
		.ID_SPACE (ID_SPACE)
	) u_slot_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (slot_ctl),
		.raddr  (slot_raddr),
		.waddr  (slot_waddr),
		.wvalid (slot_wvalid),
		.wslot  (slot_wslot),
		.rvalid (slot_rvalid),
		.rslot  (slot_rslot),
		.busy   (clr_busy)
	);

	// packed identifier list
	srds_list_mem #(
		.CAPACITY (CAPACITY)
	) u_list_mem (
		.clk   (clk),
		.ctl   (list_ctl),
		.raddr (list_raddr),
		.waddr (list_waddr),
		.wdata (list_wdata),
		.rdata (list_rdata)
	);

	// result packing
	assign m_tdata = {7'd0, res_count, res_slot};
	assign m_tuser = res_status;

	// one operation in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an operation is in flight");

	// no input while the slot records are being cleared
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s_tready)
		else $error("input ready during slot record sweep");

	// a rejected or halted operation reports slot zero
	a_reject_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_PRESENT || m_tuser == ST_FULL
			|| m_tuser == ST_FATAL)) |-> (m_tdata[7:0] == 8'd0))
		else $error("rejected operation with nonzero slot");

	// reported count never exceeds the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({23'd0, m_tdata[16:8]} <= 32'(CAPACITY)))
		else $error("count above capacity");

endmodule
